/* src/finite_difference_derivative_core_defines.svh */
// assertion macros shared by the derivative core modules
`ifndef FINITE_DIFFERENCE_DERIVATIVE_CORE_DEFINES_SVH
`define FINITE_DIFFERENCE_DERIVATIVE_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define FDD_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define FDD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/fdd_pkg.sv */
package fdd_pkg;

  // field widths fixed by the word formats
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

  // difference schemes
  localparam logic [1:0] MODE_CENTRAL  = 2'd0;
  localparam logic [1:0] MODE_FORWARD  = 2'd1;
  localparam logic [1:0] MODE_BACKWARD = 2'd2;

  // step reset value, 1.0 in Q16.16
  localparam logic [VALUE_WIDTH-1:0] STEP_RESET = 32'h0001_0000;

  // samples held in the history
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] f_value;
    logic signed [VALUE_WIDTH-1:0] x_value;
    logic                          last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] derivative;
    logic                          divide_by_zero;
    logic                          overflow;
    logic                          too_short;
    logic                          last_result;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_FIRST,
    ST_DIV_LAST,
    ST_SHORT
  } fdd_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_e;

  // which sample pair forms the difference
  typedef enum logic [1:0] {
    SEL_NEW_P0,
    SEL_P0_P1,
    SEL_NEW_P1
  } sel_e;

  typedef struct packed {
    logic [VALUE_WIDTH:0] num_mag;
    logic                 num_neg;
    logic [VALUE_WIDTH:0] den_mag;
    logic                 den_neg;
  } operand_t;

  typedef struct packed {
    logic                          busy;
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] derivative;
    logic                          divide_by_zero;
    logic                          overflow;
  } div_status_t;

endpackage

/* src/fdd_operand.sv */
module fdd_operand
  import fdd_pkg::*;
(
  input  sel_e                          sel_i,
  input  logic signed [VALUE_WIDTH-1:0] f_new_i,
  input  logic signed [VALUE_WIDTH-1:0] x_new_i,
  input  logic signed [VALUE_WIDTH-1:0] f_p0_i,
  input  logic signed [VALUE_WIDTH-1:0] x_p0_i,
  input  logic signed [VALUE_WIDTH-1:0] f_p1_i,
  input  logic signed [VALUE_WIDTH-1:0] x_p1_i,
  input  logic                          uniform_i,
  input  logic signed [VALUE_WIDTH-1:0] step_i,
  output operand_t                      operand_o
);

  logic [VALUE_WIDTH-1:0] fa, fb, xa, xb;
  logic [VALUE_WIDTH:0]   f_diff, x_diff, step_ext;
  logic [VALUE_WIDTH:0]   f_mag, x_mag, step_mag;
  logic [VALUE_WIDTH:0]   one_ext;

  assign one_ext = {{VALUE_WIDTH{1'b0}}, 1'b1};

  // pick the sample pair
  always_comb begin
    case (sel_i)
      SEL_P0_P1: begin
        fa = f_p0_i;
        fb = f_p1_i;
        xa = x_p0_i;
        xb = x_p1_i;
      end
      SEL_NEW_P1: begin
        fa = f_new_i;
        fb = f_p1_i;
        xa = x_new_i;
        xb = x_p1_i;
      end
      default: begin
        fa = f_new_i;
        fb = f_p0_i;
        xa = x_new_i;
        xb = x_p0_i;
      end
    endcase
  end

  // exact differences, one extra bit so nothing wraps
  assign f_diff   = {fa[VALUE_WIDTH-1], fa} - {fb[VALUE_WIDTH-1], fb};
  assign x_diff   = {xa[VALUE_WIDTH-1], xa} - {xb[VALUE_WIDTH-1], xb};
  assign step_ext = {step_i[VALUE_WIDTH-1], step_i};

  // sign and magnitude
  assign f_mag    = f_diff[VALUE_WIDTH] ? (~f_diff) + one_ext : f_diff;
  assign x_mag    = x_diff[VALUE_WIDTH] ? (~x_diff) + one_ext : x_diff;
  assign step_mag = step_ext[VALUE_WIDTH] ? (~step_ext) + one_ext : step_ext;

  // divisor: step (doubled over two intervals) or x difference
  always_comb begin
    operand_o.num_mag = f_mag;
    operand_o.num_neg = f_diff[VALUE_WIDTH];
    if (uniform_i) begin
      operand_o.den_neg = step_ext[VALUE_WIDTH];
      if (sel_i == SEL_NEW_P1) begin
        operand_o.den_mag = {step_mag[VALUE_WIDTH-1:0], 1'b0};
      end else begin
        operand_o.den_mag = step_mag;
      end
    end else begin
      operand_o.den_mag = x_mag;
      operand_o.den_neg = x_diff[VALUE_WIDTH];
    end
  end

endmodule

/* src/fdd_serdiv.sv */
`include "finite_difference_derivative_core_defines.svh"

module fdd_serdiv
  import fdd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  operand_t    operand_i,
  output div_status_t status_o
);

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned N_ITER = W + 1 + FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(N_ITER);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_ITER - 1);
  localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] HALF = {2'b01, {(W-2){1'b0}}};

  div_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]       num_sr_q, num_sr_d;
  logic [W:0]       den_q, den_d;
  logic [W:0]       rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic             sat_q, sat_d;
  logic             sign_q, sign_d;
  logic             zero_q, zero_d;

  logic [W+1:0]     trial, trial_sub;
  logic             ge;
  logic             neg;

  // one quotient bit per cycle: bring down the next dividend bit
  assign trial     = {rem_q, num_sr_q[W]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_sr_q <= num_sr_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    sat_q    <= sat_d;
    sign_q   <= sign_d;
    zero_q   <= zero_d;
  end

  // sequencer and datapath update
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    num_sr_d = num_sr_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    sat_d    = sat_q;
    sign_d   = sign_q;
    zero_d   = zero_q;
    case (state_q)
      DV_RUN: begin
        num_sr_d = {num_sr_q[W-1:0], 1'b0};
        rem_d    = ge ? trial_sub[W:0] : trial[W:0];
        if (!sat_q) begin
          if ((quo_q > HALF) || ((quo_q == HALF) && ge)) begin
            sat_d = 1'b1;
          end else begin
            quo_d = {quo_q[W-2:0], ge};
          end
        end
        if (cnt_q == '0) begin
          state_d = DV_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        if (start_i) begin
          num_sr_d = operand_i.num_mag;
          den_d    = operand_i.den_mag;
          rem_d    = '0;
          quo_d    = '0;
          sat_d    = 1'b0;
          sign_d   = operand_i.num_neg ^ operand_i.den_neg;
          zero_d   = (operand_i.den_mag == '0);
          cnt_d    = CNT_LAST;
          state_d  = (operand_i.den_mag == '0) ? DV_DONE : DV_RUN;
        end
      end
    endcase
  end

  // sign, saturation and zero divisor
  assign neg = sign_q && (quo_q != '0);

  always_comb begin
    status_o.busy           = (state_q == DV_RUN);
    status_o.done           = (state_q == DV_DONE);
    status_o.divide_by_zero = 1'b0;
    status_o.overflow       = 1'b0;
    if (zero_q) begin
      status_o.derivative     = '0;
      status_o.divide_by_zero = 1'b1;
    end else if (neg) begin
      if (sat_q) begin
        status_o.derivative = LIM;
        status_o.overflow   = 1'b1;
      end else begin
        status_o.derivative = (~quo_q) + {{(W-1){1'b0}}, 1'b1};
      end
    end else if (sat_q || (quo_q == LIM)) begin
      status_o.derivative = ~LIM;
      status_o.overflow   = 1'b1;
    end else begin
      status_o.derivative = quo_q;
    end
  end

  `FDD_ASSERT_SAME(a_start_not_running, start_i, state_q != DV_RUN, "divider restarted mid-run")
  `FDD_ASSERT_SAME(a_cnt_range, state_q == DV_RUN, cnt_q <= CNT_LAST, "bit counter out of range")
  `FDD_ASSERT_SAME(a_zero_no_sat, (state_q == DV_DONE) && zero_q, !sat_q, "zero divisor saturated")

endmodule

/* src/finite_difference_derivative_core.sv */
// channel | direction | handshake            | word
// in      | input     | in_valid_i/in_stall_o | in_i: f_value, x_value, last_sample
// out     | output    | out_valid_o/out_stall_i | out_o: derivative and flags
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// the serial divider retires one quotient bit per cycle while running; a zero divisor skips
// the run and goes straight to done; the input frees in the cycle after the word's last quotient
// is loaded into the output register: one quotient for a word, two for a final sample; a first
// sample does not stall the input, and a single-sample sequence waits only for its too_short word
// reset is asynchronous: config returns to reset values and the sample count clears
// a stalled output holds its word; a finished quotient waits in the divider, input stays stalled
`include "finite_difference_derivative_core_defines.svh"

module finite_difference_derivative_core
  import fdd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_word_t               in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_word_t              out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i
);

  fdd_state_e state_q, state_d;
  logic [1:0] seen_q, seen_d;
  logic [1:0] mode_q;
  logic       uniform_q;
  logic signed [VALUE_WIDTH-1:0] step_q;

  logic signed [VALUE_WIDTH-1:0] f_q, x_q;
  logic                          last_q;
  logic signed [VALUE_WIDTH-1:0] f_p0_q, x_p0_q, f_p1_q, x_p1_q;

  out_word_t out_q, out_word;
  logic      out_valid_q;

  logic        in_accept, slot_free, load_out;
  logic        capture, hist_load, hist_shift, div_start;
  sel_e        sel, first_sel;
  logic signed [VALUE_WIDTH-1:0] f_new, x_new;
  operand_t    operand;
  div_status_t div_status;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CENTRAL;
      uniform_q <= 1'b0;
      step_q    <= STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        CFG_UNIFORM: uniform_q <= cfg_data_i[0];
        CFG_STEP:    step_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= SEEN_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample history and held input word
  always_ff @(posedge clk_i) begin
    if (capture) begin
      f_q    <= in_i.f_value;
      x_q    <= in_i.x_value;
      last_q <= in_i.last_sample;
    end
    if (hist_load) begin
      f_p0_q <= in_i.f_value;
      x_p0_q <= in_i.x_value;
    end else if (hist_shift) begin
      f_p1_q <= f_p0_q;
      x_p1_q <= x_p0_q;
      f_p0_q <= f_q;
      x_p0_q <= x_q;
    end
    if (load_out) begin
      out_q <= out_word;
    end
  end

  // difference scheme of the first quotient
  always_comb begin
    if (seen_q == SEEN_ONE) begin
      first_sel = SEL_NEW_P0;
    end else begin
      case (mode_q)
        MODE_FORWARD:  first_sel = SEL_NEW_P0;
        MODE_BACKWARD: first_sel = SEL_P0_P1;
        MODE_CENTRAL:  first_sel = SEL_NEW_P1;
        default:       first_sel = SEL_NEW_P1;
      endcase
    end
  end

  assign sel   = (state_q == ST_IDLE) ? first_sel : SEL_NEW_P0;
  assign f_new = (state_q == ST_IDLE) ? in_i.f_value : f_q;
  assign x_new = (state_q == ST_IDLE) ? in_i.x_value : x_q;

  fdd_operand u_operand (
    .sel_i     (sel),
    .f_new_i   (f_new),
    .x_new_i   (x_new),
    .f_p0_i    (f_p0_q),
    .x_p0_i    (x_p0_q),
    .f_p1_i    (f_p1_q),
    .x_p1_i    (x_p1_q),
    .uniform_i (uniform_q),
    .step_i    (step_q),
    .operand_o (operand)
  );

  fdd_serdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_serdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .operand_i (operand),
    .status_o  (div_status)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    capture    = 1'b0;
    hist_load  = 1'b0;
    hist_shift = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    out_word                = '0;
    out_word.derivative     = div_status.derivative;
    out_word.divide_by_zero = div_status.divide_by_zero;
    out_word.overflow       = div_status.overflow;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          capture = 1'b1;
          if (seen_q == SEEN_NONE) begin
            if (in_i.last_sample) begin
              state_d = ST_SHORT;
            end else begin
              hist_load = 1'b1;
              seen_d    = SEEN_ONE;
            end
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV_FIRST;
          end
        end
      end
      ST_DIV_FIRST: begin
        if (div_status.done && slot_free) begin
          load_out = 1'b1;
          if (last_q) begin
            div_start = 1'b1;
            state_d   = ST_DIV_LAST;
          end else begin
            hist_shift = 1'b1;
            seen_d     = SEEN_TWO;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_DIV_LAST: begin
        out_word.last_result = 1'b1;
        if (div_status.done && slot_free) begin
          load_out = 1'b1;
          seen_d   = SEEN_NONE;
          state_d  = ST_IDLE;
        end
      end
      ST_SHORT: begin
        out_word             = '0;
        out_word.too_short   = 1'b1;
        out_word.last_result = 1'b1;
        if (slot_free) begin
          load_out = 1'b1;
          seen_d   = SEEN_NONE;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `FDD_ASSERT_SAME(a_no_overwrite, load_out, slot_free, "output word overwritten")
  `FDD_ASSERT_SAME(a_idle_div_quiet, state_q == ST_IDLE, !div_status.busy, "divider busy while idle")
  `FDD_ASSERT_NEXT(a_last_clears, load_out && out_word.last_result, seen_q == SEEN_NONE, "count kept after last")

endmodule

/* tb/fdd_result_checker.sv */
`timescale 1ns / 1ps

module fdd_result_checker
  import fdd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_word_t               in_word_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_word_t              out_word_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  output int                     mismatch_count_o,
  output int                     pending_count_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned FB = FRAC_BITS_DEF;

  typedef logic signed [W-1:0] value_t;
  typedef logic signed [W+1:0] wide_t;

  localparam value_t         MOST_POS  = {1'b0, {(W-1){1'b1}}};
  localparam value_t         MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] NEG_LIMIT = {{(W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] POS_LIMIT = NEG_LIMIT - 1;

  // shadow of the config registers and the sample history
  logic [1:0] scheme_q  = MODE_CENTRAL;
  logic       uniform_q = 1'b0;
  value_t     step_q    = STEP_RESET;
  value_t     hist_f [2];
  value_t     hist_x [2];
  logic [1:0] seen_q    = SEEN_NONE;

  out_word_t  expected_derivs [$];
  int         mismatches = 0;

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
    hist_f[0] = '0;
    hist_f[1] = '0;
    hist_x[0] = '0;
    hist_x[1] = '0;
  end

  function automatic wide_t widen(value_t v);
    return {{2{v[W-1]}}, v};
  endfunction

  // (fa - fb) / divisor on exact magnitudes, truncated, saturated
  function automatic out_word_t difference_quotient(value_t fa, value_t fb, value_t xa,
                                                    value_t xb, logic doubled, logic last);
    wide_t          num;
    wide_t          den;
    logic [W+1:0]   num_mag;
    logic [W+1:0]   den_mag;
    logic [2*W-1:0] quo;
    logic           neg;
    out_word_t      w;
    num = widen(fa) - widen(fb);
    if (uniform_q) begin
      den = widen(step_q);
      if (doubled) begin
        den = den <<< 1;
      end
    end else begin
      den = widen(xa) - widen(xb);
    end
    num_mag = num[W+1] ? -num : num;
    den_mag = den[W+1] ? -den : den;
    w = '0;
    w.last_result = last;
    if (den_mag == '0) begin
      w.divide_by_zero = 1'b1;
      return w;
    end
    quo = ({{(W-2){1'b0}}, num_mag} << FB) / {{(W-2){1'b0}}, den_mag};
    neg = (num[W+1] != den[W+1]) && (quo != '0);
    if (neg) begin
      if (quo > NEG_LIMIT) begin
        w.derivative = MOST_NEG;
        w.overflow   = 1'b1;
      end else begin
        w.derivative = -quo[W-1:0];
      end
    end else begin
      if (quo > POS_LIMIT) begin
        w.derivative = MOST_POS;
        w.overflow   = 1'b1;
      end else begin
        w.derivative = quo[W-1:0];
      end
    end
    return w;
  endfunction

  // queue the derivatives that one sample releases
  task automatic record_sample(in_word_t w);
    if (seen_q == SEEN_NONE) begin
      if (w.last_sample) begin
        expected_derivs.push_back('{derivative: '0, divide_by_zero: 1'b0, overflow: 1'b0,
                                    too_short: 1'b1, last_result: 1'b1});
      end else begin
        hist_f[0] = w.f_value;
        hist_x[0] = w.x_value;
        seen_q    = SEEN_ONE;
      end
      return;
    end
    if (seen_q == SEEN_ONE || scheme_q == MODE_FORWARD) begin
      expected_derivs.push_back(difference_quotient(w.f_value, hist_f[0], w.x_value,
                                                    hist_x[0], 1'b0, 1'b0));
    end else if (scheme_q == MODE_BACKWARD) begin
      expected_derivs.push_back(difference_quotient(hist_f[0], hist_f[1], hist_x[0],
                                                    hist_x[1], 1'b0, 1'b0));
    end else begin
      expected_derivs.push_back(difference_quotient(w.f_value, hist_f[1], w.x_value,
                                                    hist_x[1], 1'b1, 1'b0));
    end
    if (w.last_sample) begin
      // endpoint uses the one-sided difference of the last pair
      expected_derivs.push_back(difference_quotient(w.f_value, hist_f[0], w.x_value,
                                                    hist_x[0], 1'b0, 1'b1));
      seen_q = SEEN_NONE;
    end else begin
      hist_f[1] = hist_f[0];
      hist_x[1] = hist_x[0];
      hist_f[0] = w.f_value;
      hist_x[0] = w.x_value;
      seen_q    = SEEN_TWO;
    end
  endtask

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    if (mismatches < 100) begin
      $display("%0t checker: %s got %h want %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (expected_derivs.size() == 0) begin
      report_mismatch("unexpected word, derivative", got.derivative, '0);
      return;
    end
    want = expected_derivs.pop_front();
    if (got.derivative !== want.derivative) begin
      report_mismatch("derivative", got.derivative, want.derivative);
    end
    if (got.divide_by_zero !== want.divide_by_zero) begin
      report_mismatch("divide_by_zero", W'(got.divide_by_zero), W'(want.divide_by_zero));
    end
    if (got.overflow !== want.overflow) begin
      report_mismatch("overflow", W'(got.overflow), W'(want.overflow));
    end
    if (got.too_short !== want.too_short) begin
      report_mismatch("too_short", W'(got.too_short), W'(want.too_short));
    end
    if (got.last_result !== want.last_result) begin
      report_mismatch("last_result", W'(got.last_result), W'(want.last_result));
    end
  endtask

  // sample mid-cycle: handshakes seen here complete at the next rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      scheme_q  = MODE_CENTRAL;
      uniform_q = 1'b0;
      step_q    = STEP_RESET;
      hist_f[0] = '0;
      hist_f[1] = '0;
      hist_x[0] = '0;
      hist_x[1] = '0;
      seen_q    = SEEN_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE:    scheme_q  = cfg_data_i[1:0];
          CFG_UNIFORM: uniform_q = cfg_data_i[0];
          CFG_STEP:    step_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        record_sample(in_word_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_word(out_word_i);
      end
    end
    pending_count_o  = expected_derivs.size();
    mismatch_count_o = mismatches;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fdd_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned TARGET_ITEMS  = 1950;
  localparam int unsigned PHASE_ITEMS   = 150;

  localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE   = 32'sh0001_0000;

  // unused scheme code, decoded as central
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_style_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_MODE;
  logic [VALUE_WIDTH-1:0] cfg_data  = '0;

  int mismatch_count;
  int pending_count;
  int burst_left = 0;
  int items_sent = 0;

  stall_style_e stall_style = STALL_NONE;
  logic [7:0]   stall_cycle = '0;
  int           run_left    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  finite_difference_derivative_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fdd_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // output back-pressure: style is redrawn each time the 8-bit cycle counter wraps
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle == 8'd0) begin
      stall_style <= stall_style_e'($urandom_range(0, 2));
    end
    case (stall_style)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left  <= $urandom_range(1, 24);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // end the run when no channel moves a word for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // one sample word, sent in bursts with random gaps
  task automatic send_sample(logic signed [31:0] f, logic signed [31:0] x, logic last);
    int       gap;
    logic     taken;
    in_word_t w;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    w.f_value     = f;
    w.x_value     = x;
    w.last_sample = last;
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      @(posedge clk);
    end while (!taken);
    burst_left--;
    items_sent++;
  endtask

  // keeps cfg_valid high; the caller lowers it after the last register
  task automatic push_register(logic [CFG_IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // drain all expected words, let the core go idle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(logic [1:0] m, logic u, logic signed [31:0] s);
    drain();
    push_register(CFG_MODE, {{(VALUE_WIDTH-2){1'b0}}, m});
    push_register(CFG_UNIFORM, {{(VALUE_WIDTH-1){1'b0}}, u});
    push_register(CFG_STEP, s);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_f(logic signed [31:0] prev);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      return $urandom_range(0, 1 << 20) - (1 << 19);
    end else if (sel <= 5) begin
      return prev + ($urandom_range(0, 1 << 17) - (1 << 16));
    end else if (sel <= 7) begin
      return $urandom();
    end else if (sel == 8) begin
      case ($urandom_range(0, 3))
        0:       return V_MAX;
        1:       return V_MIN;
        2:       return '0;
        default: return -1;
      endcase
    end
    return prev;
  endfunction

  // mostly rising abscissas, now and then a repeat or a jump
  function automatic logic signed [31:0] pick_x(logic signed [31:0] prev);
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel <= 12) begin
      return prev + $urandom_range(1, 1 << 18);
    end else if (sel == 13) begin
      return prev;
    end else if (sel == 14) begin
      return prev - $urandom_range(1, 1 << 18);
    end
    return $urandom();
  endfunction

  task automatic send_sequence(int len);
    logic signed [31:0] f;
    logic signed [31:0] x;
    f = pick_f('0);
    x = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
    for (int i = 0; i < len; i++) begin
      send_sample(f, x, i == len - 1);
      f = pick_f(f);
      x = pick_x(x);
    end
  endtask

  function automatic logic signed [31:0] pick_step();
    case ($urandom_range(0, 6))
      0:       return ONE;
      1:       return $urandom_range(1, 4 << 16);
      2:       return -$urandom_range(1, 4 << 16);
      3:       return '0;
      4:       return V_MIN;
      5:       return V_MAX;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: central, spacing from x
    send_sample(5 * ONE, '0, 1'b1);
    send_sample('0, '0, 1'b0);
    send_sample(ONE, ONE, 1'b1);
    send_sample(32'sd3, 7 * ONE, 1'b0);
    send_sample(32'sd9, 7 * ONE, 1'b1);
    send_sample('0, '0, 1'b0);
    send_sample(V_MIN, ONE, 1'b1);
    send_sample('0, '0, 1'b0);
    send_sample(V_MAX, 32'sd1, 1'b0);
    send_sample(V_MIN, 32'sd2, 1'b0);
    send_sample(V_MAX, V_MAX, 1'b1);
    send_sample(V_MAX, V_MIN, 1'b0);
    send_sample(V_MIN, V_MAX, 1'b1);

    // forward with a zero step
    reconfigure(MODE_FORWARD, 1'b1, '0);
    send_sample(32'sd1, V_MAX, 1'b0);
    send_sample(32'sd2, V_MIN, 1'b0);
    send_sample(32'sd3, '0, 1'b1);

    // backward with the most negative step
    reconfigure(MODE_BACKWARD, 1'b1, V_MIN);
    send_sample(V_MAX, '0, 1'b0);
    send_sample(V_MIN, '0, 1'b0);
    send_sample(V_MAX, '0, 1'b0);
    send_sample('0, '0, 1'b1);

    // central over a doubled largest step
    reconfigure(MODE_CENTRAL, 1'b1, V_MAX);
    send_sample(V_MIN, -1, 1'b0);
    send_sample('0, -1, 1'b0);
    send_sample(V_MAX, -1, 1'b1);

    // spare scheme code
    reconfigure(MODE_SPARE, 1'b0, ONE);
    send_sample('0, '0, 1'b0);
    send_sample(ONE, ONE, 1'b0);
    send_sample(4 * ONE, 2 * ONE, 1'b1);

    // random phases: well-formed sequences with some loose words mixed in
    while (items_sent < TARGET_ITEMS) begin
      reconfigure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_step());
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_sample($urandom(), $urandom(), $urandom_range(0, 2) == 0);
        end else if ($urandom_range(0, 9) == 0) begin
          send_sequence($urandom_range(9, 24));
        end else begin
          send_sequence($urandom_range(1, 8));
        end
      end
    end

    drain();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
